FILE: hdl/lpht_pkg.sv
package lpht_pkg;

  localparam int HASH_W = 32;
  localparam int KEY_IN_W = 32;
  localparam int OUT_W = 10;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [OUT_W-1:0] MAX_ITEMS_RESET = 10'd768;

  typedef struct packed {
    logic key_we;
    logic used_we;
  } mem_ctl_t;

endpackage

FILE: hdl/lpht_mod.sv
module lpht_mod #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [lpht_pkg::HASH_W-1:0]   hash,
  output logic                          valid,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  localparam int IW = $clog2(TABLE_SIZE);

  generate
    if ((1 << IW) == TABLE_SIZE) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          valid <= 1'b0;
        end else if (go) begin
          valid <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          home <= IW'(hash);
        end
      end
    end else begin : g_recip
      localparam int PW = 2 * lpht_pkg::HASH_W;
      localparam int SH = lpht_pkg::HASH_W + IW;
      localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
      localparam logic [lpht_pkg::HASH_W-1:0] RECIP_LO = RECIP[lpht_pkg::HASH_W-1:0];
      localparam logic RECIP_HI = RECIP[lpht_pkg::HASH_W];
      localparam logic [IW-1:0] TS_LO = IW'(TABLE_SIZE);

      logic                        stage1;
      logic                        stage2;
      logic [lpht_pkg::HASH_W-1:0] hash_q;
      logic [PW-1:0]               prod_lo;
      logic [PW:0]                 prod;
      logic [IW-1:0]               quot;

      // quotient by reciprocal multiply, then hash minus quotient times size
      assign prod_lo = PW'(hash_q) * PW'(RECIP_LO);
      assign prod    = {1'b0, prod_lo} +
                       (RECIP_HI ? {1'b0, hash_q, {lpht_pkg::HASH_W{1'b0}}} : '0);

      always_ff @(posedge clk) begin
        if (rst) begin
          valid  <= 1'b0;
          stage1 <= 1'b0;
          stage2 <= 1'b0;
        end else begin
          stage1 <= go;
          stage2 <= stage1;
          if (go) begin
            valid <= 1'b0;
          end else if (stage2) begin
            valid <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          hash_q <= hash;
        end
        if (stage1) begin
          quot <= prod[SH +: IW];
        end
        if (stage2) begin
          home <= hash_q[IW-1:0] - quot * TS_LO;
        end
      end
    end
  endgenerate

endmodule

FILE: hdl/lpht_mem.sv
module lpht_mem #(
  parameter int AW = 10,
  parameter int KW = 32
) (
  input  logic               clk,
  input  lpht_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      wr_addr,
  input  logic [KW-1:0]      wr_key,
  input  logic               wr_used,
  input  logic [AW-1:0]      rd_addr,
  output logic [KW-1:0]      rd_key,
  output logic               rd_used
);

  localparam int DEPTH = 1 << AW;

  logic [KW-1:0] key_mem  [DEPTH];
  logic          used_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.used_we) begin
      used_mem[wr_addr] <= wr_used;
    end
    rd_used <= used_mem[rd_addr];
  end

endmodule

FILE: hdl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, keys held in block memory.
// Command channel: an item (mode, key, key_hash) is taken on a clock edge
// with start high and busy low. Mode lookup probes from key_hash mod
// TABLE_SIZE for the key, insert stores it in the first empty slot, clear
// empties the table. Config: max_items is written on any edge with
// max_items_we high; an insert of a new key is refused once the count
// reaches it.
// Result channel: done is high for one cycle with status, slot and
// stored_count; one result per item. The receiver cannot stall, so results
// are never held back.
// Probing: one slot probe per cycle out of the read port of the table
// memory. A lookup or insert visits 1 to TABLE_SIZE slots. With a
// TABLE_SIZE that is not a power of two, the home slot comes from a
// reciprocal multiply registered through hash_q, quot and home. Clear
// sweeps every slot; the unused mode is answered straight from idle.
// busy stays high until the result cycle for lookup, insert and clear, so
// one item is in flight at a time. Reset: the used bits are swept to zero
// with busy high; the count clears and max_items returns to 768.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [lpht_pkg::KEY_IN_W-1:0]  key,
  input  logic [lpht_pkg::HASH_W-1:0]    key_hash,
  input  logic                           max_items_we,
  input  logic [lpht_pkg::OUT_W-1:0]     max_items,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [lpht_pkg::OUT_W-1:0]     slot,
  output logic [lpht_pkg::OUT_W-1:0]     stored_count
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [1:0]                 mode_q;
  logic [KEY_WIDTH-1:0]       key_q;
  logic [IW-1:0]              cur_idx;
  logic [IW-1:0]              probe_cnt;
  logic [IW-1:0]              sweep_addr;
  logic                       sweep_reply;
  logic [lpht_pkg::OUT_W-1:0] count;
  logic [lpht_pkg::OUT_W-1:0] max_items_q;

  logic                       accept;
  logic                       hash_go;
  logic                       hash_valid;
  logic [IW-1:0]              home;
  logic [IW-1:0]              rd_addr;
  logic [IW-1:0]              next_idx;
  logic [IW-1:0]              wr_addr;
  logic [KEY_WIDTH-1:0]       rd_key;
  logic                       rd_used;
  lpht_pkg::mem_ctl_t         mem_ctl;

  logic                       hit_key;
  logic                       hit_empty;
  logic                       probe_end;
  logic                       can_insert;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign hash_go = accept && (mode == lpht_pkg::MODE_LOOKUP || mode == lpht_pkg::MODE_INSERT);

  lpht_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .go   (hash_go),
    .hash (key_hash),
    .valid(hash_valid),
    .home (home)
  );

  assign hit_empty  = !rd_used;
  assign hit_key    = rd_used && (rd_key == key_q);
  assign probe_end  = hit_empty || hit_key || (probe_cnt == LAST_IDX);
  assign can_insert = hit_empty && (count < max_items_q);
  assign next_idx   = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;

  always_comb begin
    case (state)
      S_HASH:  rd_addr = home;
      S_PROBE: rd_addr = next_idx;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    mem_ctl = '0;
    wr_addr = cur_idx;
    if (state == S_SWEEP) begin
      mem_ctl.used_we = 1'b1;
      wr_addr         = sweep_addr;
    end else if (state == S_PROBE && probe_end && !hit_key &&
                 mode_q == lpht_pkg::MODE_INSERT && can_insert) begin
      mem_ctl.used_we = 1'b1;
      mem_ctl.key_we  = 1'b1;
    end
  end

  lpht_mem #(
    .AW(IW),
    .KW(KEY_WIDTH)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_key (key_q),
    .wr_used(state != S_SWEEP),
    .rd_addr(rd_addr),
    .rd_key (rd_key),
    .rd_used(rd_used)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && hash_go) begin
          state_next = S_HASH;
        end else if (accept && mode == lpht_pkg::MODE_CLEAR) begin
          state_next = S_SWEEP;
        end
      end
      S_HASH: begin
        if (hash_valid) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_end) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sweep_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      count       <= '0;
      max_items_q <= lpht_pkg::MAX_ITEMS_RESET;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (max_items_we) begin
        max_items_q <= max_items;
      end
      case (state)
        S_IDLE: begin
          if (accept && mode == lpht_pkg::MODE_CLEAR) begin
            sweep_addr  <= '0;
            sweep_reply <= 1'b1;
            count       <= '0;
          end else if (accept && !hash_go) begin
            // unused mode
            done         <= 1'b1;
            status       <= lpht_pkg::ST_NOT_FOUND;
            slot         <= '0;
            stored_count <= count;
          end
        end
        S_PROBE: begin
          if (probe_end) begin
            done <= 1'b1;
            if (hit_key) begin
              status       <= (mode_q == lpht_pkg::MODE_LOOKUP) ?
                              lpht_pkg::ST_OK : lpht_pkg::ST_DUPLICATE;
              slot         <= lpht_pkg::OUT_W'(cur_idx);
              stored_count <= count;
            end else if (mode_q == lpht_pkg::MODE_LOOKUP) begin
              status       <= lpht_pkg::ST_NOT_FOUND;
              slot         <= '0;
              stored_count <= count;
            end else if (can_insert) begin
              status       <= lpht_pkg::ST_OK;
              slot         <= lpht_pkg::OUT_W'(cur_idx);
              stored_count <= count + 1'b1;
              count        <= count + 1'b1;
            end else begin
              status       <= lpht_pkg::ST_FULL;
              slot         <= '0;
              stored_count <= count;
            end
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_IDX && sweep_reply) begin
            done         <= 1'b1;
            status       <= lpht_pkg::ST_OK;
            slot         <= '0;
            stored_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_idx <= rd_addr;
    if (accept) begin
      mode_q <= mode;
      key_q  <= KEY_WIDTH'(key);
    end
    if (state == S_HASH) begin
      probe_cnt <= '0;
    end else if (state == S_PROBE) begin
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

endmodule
